// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by checker modules. Both assume clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vla_pkg.sv =====
package vla_pkg;

  // Result level width and configuration register width
  localparam int LEVEL_W = 12;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  // Register indexes
  localparam cfg_idx_t REG_THRESHOLD = 2'd0;
  localparam cfg_idx_t REG_GAP       = 2'd1;

  // Register reset values
  localparam cfg_word_t THRESHOLD_RESET = 12'd100;
  localparam cfg_word_t GAP_RESET       = 12'd20;

endpackage

// ===== hdl/vla_ram.sv =====
module vla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/vibration_level_alarm_core.sv =====
// Vibration level alarm. Each sample beat yields one result beat: the mean
// absolute difference between consecutive samples over the last WINDOW
// samples (rounded half up, 0 until WINDOW samples have gone before), plus a
// hysteresis alarm that sets when level > alarm_threshold and clears when
// level < alarm_threshold - release_gap (never clears if that is <= 0).
// Throughput is one sample per clock while the output side does not stall.
// The four stages are: sample register (with the difference ring read),
// running sum update, constant-reciprocal divide, and the hysteresis compare
// into the output register. Registers may be written only while no beat is
// in flight.
// The difference ring is not cleared after reset; a warm-up count masks the
// unwritten entries, so the block accepts samples right out of reset.
module vibration_level_alarm_core #(
  parameter int WINDOW      = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  // sample channel
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic [SAMPLE_BITS-1:0]      sample,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [vla_pkg::LEVEL_W-1:0] level,
  output logic                        alarm,
  output logic                        alarm_changed,
  // register write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vla_pkg::CFG_W-1:0]   cfg_data
);

  // ---------------------------------------------------------------- sizes
  localparam int CLW    = $clog2(WINDOW);
  localparam int POS_W  = CLW;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CLW;   // holds WINDOW * max diff
  localparam int NUM_W  = SUM_W + 1;           // 2*sum + WINDOW
  localparam int DIV    = 2 * WINDOW;
  localparam int CLD    = $clog2(DIV);
  localparam int SHIFT  = NUM_W + CLD;
  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int Q_W    = PROD_W - SHIFT;
  localparam int LVL_W  = vla_pkg::LEVEL_W;
  // full-width level for the alarm compare; only the low LVL_W bits go out
  localparam int CL_W    = Q_W + LVL_W;
  localparam int THR_EXT = CL_W - vla_pkg::CFG_W;

  // ceil(2^SHIFT / DIV): floor(n * RCP >> SHIFT) == floor(n / DIV) for n < 2^NUM_W
  localparam logic [63:0] ONE64 = 64'd1;
  localparam logic [63:0] RCP64 = ((ONE64 << SHIFT) + DIV - 1) / DIV;
  localparam logic [RCP_W-1:0] RCP = RCP64[RCP_W-1:0];

  localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);
  localparam logic [NUM_W-1:0] HALF_ADD = NUM_W'(WINDOW);

  // ---------------------------------------------------------------- config
  logic [vla_pkg::CFG_W-1:0] alarm_threshold;
  logic [vla_pkg::CFG_W-1:0] release_gap;

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- state
  logic [SAMPLE_BITS-1:0] prev_sample;
  logic [POS_W-1:0]       ring_pos;
  logic [POS_W-1:0]       ring_pos_next;
  logic [SUM_W-1:0]       diff_sum;
  logic [SUM_W-1:0]       diff_sum_next;
  logic [CNT_W-1:0]       warm_cnt;
  logic [CNT_W-1:0]       warm_cnt_next;
  logic                   alarm_state;
  logic                   alarm_state_next;

  // pipeline registers
  logic                   a_valid;
  logic [SAMPLE_BITS-1:0] a_sample;
  logic                   b_valid;
  logic [NUM_W-1:0]       b_num;
  logic                   b_full;
  logic                   c_valid;
  logic [CL_W-1:0]        c_level;
  logic [LVL_W-1:0]       level_reg;
  logic                   changed_reg;

  // ---------------------------------------------------------------- flow
  // Each stage advances when the one after it is empty or leaving.
  logic out_free, c_go, c_free, b_go, b_free, a_go, a_free, accept;

  assign out_free = !result_valid || !result_stall;
  assign c_go     = c_valid && out_free;
  assign c_free   = !c_valid || c_go;
  assign b_go     = b_valid && c_free;
  assign b_free   = !b_valid || b_go;
  assign a_go     = a_valid && b_free;
  assign a_free   = !a_valid || a_go;
  assign sample_stall = !a_free;
  assign accept   = sample_valid && a_free;

  // ---------------------------------------------------------------- ring
  // Read is issued with the accept so the old entry lines up with a_sample.
  // The read address is the position after any update this cycle.
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic [SAMPLE_BITS-1:0] diff;

  vla_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (a_go),
    .wr_addr (ring_pos),
    .wr_data (diff),
    .rd_en   (accept),
    .rd_addr (ring_pos_next),
    .rd_data (ring_rd)
  );

  // ---------------------------------------------------------------- stage A
  logic                   ring_full;
  logic [SAMPLE_BITS-1:0] old_diff;
  logic [NUM_W-1:0]       num_next;

  assign diff = (a_sample >= prev_sample) ? (a_sample - prev_sample)
                                          : (prev_sample - a_sample);

  // Warm-up count saturates at WINDOW; below that the slot was never written.
  assign ring_full = (warm_cnt == WIN_CNT);
  assign old_diff  = ring_full ? ring_rd : '0;

  assign diff_sum_next = diff_sum - {{CLW{1'b0}}, old_diff} + {{CLW{1'b0}}, diff};
  assign num_next      = {diff_sum_next, 1'b0} + HALF_ADD;

  always_comb begin
    ring_pos_next = ring_pos;
    warm_cnt_next = warm_cnt;
    if (a_go) begin
      ring_pos_next = (ring_pos == LAST_POS) ? '0 : ring_pos + 1'b1;
      if (!ring_full) begin
        warm_cnt_next = warm_cnt + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stage B
  // Divide by 2*WINDOW through a reciprocal multiply.
  logic [PROD_W-1:0]      prod;
  logic [Q_W-1:0]         quot;
  logic [CL_W-1:0]        quot_ext;

  assign prod     = {{RCP_W{1'b0}}, b_num} * {{NUM_W{1'b0}}, RCP};
  assign quot     = prod[PROD_W-1:SHIFT];
  assign quot_ext = {{LVL_W{1'b0}}, quot};

  // ---------------------------------------------------------------- stage C
  // Hysteresis: low mark is signed, so a gap above threshold never clears.
  logic signed [CL_W:0] low_mark;
  logic signed [CL_W:0] level_s;

  assign low_mark = $signed({{(THR_EXT + 1){1'b0}}, alarm_threshold})
                  - $signed({{(THR_EXT + 1){1'b0}}, release_gap});
  assign level_s  = $signed({1'b0, c_level});

  always_comb begin
    if (alarm_state) begin
      alarm_state_next = !(level_s < low_mark);
    end else begin
      alarm_state_next = (c_level > {{THR_EXT{1'b0}}, alarm_threshold});
    end
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      b_valid         <= 1'b0;
      c_valid         <= 1'b0;
      result_valid    <= 1'b0;
      prev_sample     <= '0;
      ring_pos        <= '0;
      diff_sum        <= '0;
      warm_cnt        <= '0;
      alarm_state     <= 1'b0;
      alarm_threshold <= vla_pkg::THRESHOLD_RESET;
      release_gap     <= vla_pkg::GAP_RESET;
    end else begin
      if (a_free) begin
        a_valid <= accept;
      end
      if (b_free) begin
        b_valid <= a_go;
      end
      if (c_free) begin
        c_valid <= b_go;
      end
      if (out_free) begin
        result_valid <= c_go;
      end
      if (a_go) begin
        prev_sample <= a_sample;
        diff_sum    <= diff_sum_next;
      end
      ring_pos <= ring_pos_next;
      warm_cnt <= warm_cnt_next;
      if (c_go) begin
        alarm_state <= alarm_state_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          vla_pkg::REG_THRESHOLD: alarm_threshold <= cfg_data;
          vla_pkg::REG_GAP:       release_gap     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample <= sample;
    end
    if (a_go) begin
      b_num  <= num_next;
      b_full <= ring_full;
    end
    if (b_go) begin
      c_level <= b_full ? quot_ext : '0;
    end
    if (c_go) begin
      level_reg   <= c_level[LVL_W-1:0];
      changed_reg <= (alarm_state_next != alarm_state);
    end
  end

  assign level         = level_reg;
  assign alarm         = alarm_state;
  assign alarm_changed = changed_reg;

endmodule

// ===== hdl/vla_checker.sv =====
`include "assert_macros.svh"

module vla_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [vla_pkg::LEVEL_W-1:0] level,
  input logic                        alarm,
  input logic                        alarm_changed,
  input logic                        cfg_valid,
  input logic                        cfg_ready
);

  `VLA_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(level) && $stable(alarm) && $stable(alarm_changed), "stalled result beat changed")

  `VLA_ASSERT_IMP(a_set_needs_level, result_valid && alarm && alarm_changed, level != '0, "alarm set on a zero level")

  `VLA_ASSERT_IMP(a_quiet_after_reset, $past(rst), !result_valid, "result beat right after reset")

  `VLA_ASSERT_IMP(a_cfg_always_ready, cfg_valid, cfg_ready, "register write refused")

endmodule

bind vibration_level_alarm_core vla_checker u_vla_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .level         (level),
  .alarm         (alarm),
  .alarm_changed (alarm_changed),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
